>>> hw/rtl/assert_macros.svh
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is asserted
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> hw/rtl/btffa_pkg.sv
// types and codes of the boundary tag first fit allocator
package btffa_pkg;

    // request kinds
    localparam logic FN_ALLOC = 1'b0;
    localparam logic FN_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OOM  = 2'd1;
    localparam logic [1:0] ST_NULL = 2'd2;

    // byte offsets into the heap, wide enough to wrap like unsigned arithmetic
    typedef logic [31:0] t_off;
    typedef logic [15:0] t_word;

    localparam t_off  HDR_BYTES = 32'd4;
    localparam t_word END_MARK  = 16'd1;
    localparam t_word SIZE_MASK = 16'hFFFE;

endpackage

>>> hw/rtl/boundary_tag_first_fit_allocator.sv
// boundary tag first fit heap allocator over a single word memory
// A transaction on the input either allocates req_size bytes or frees a payload
// offset; exactly one result transaction follows each input. All heap state sits
// in one memory of HEAP_WORDS 16-bit words with one write and one read port and a
// registered read, walked by a sequencer one access per cycle. An allocate is
// accepted, visits block headers from offset 0 up to the break, then reports out
// of memory, marks an exact fit, or splits a free block or grows at the break
// before marking it and presenting the result; a free clears the flags, merges
// with a free next and previous block and may lower the break. A waiting
// result holds the sequencer in S_DONE until the receiver takes it. Reset clears
// only the state, the break and the output valid flag; no memory clear is run.
`include "assert_macros.svh"

module boundary_tag_first_fit_allocator #(
    parameter int HEAP_WORDS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // req_size[13:0], payload_addr[27:14], zero pad
    input  logic [0:0]  s_axis_tuser,  // func[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // alloc_addr[13:0], zero pad
    output logic [1:0]  m_axis_tuser   // status[1:0]
);

    localparam int AW  = $clog2(HEAP_WORDS);
    localparam int CAP = HEAP_WORDS * 4;
    localparam int BW  = $clog2(CAP + 1);
    localparam btffa_pkg::t_off CAP_OFF = btffa_pkg::t_off'(CAP);

    typedef enum logic [4:0] {
        S_IDLE, S_A_CHK, S_A_WALK, S_G0, S_G1, S_G2,
        S_SP1, S_SP2, S_SP3, S_SP4,
        S_MU0, S_MU1, S_MU2, S_MU3,
        S_F0, S_F1, S_F2, S_F3, S_F4, S_F5, S_F6, S_F7, S_F8,
        S_F9, S_F10, S_F11, S_F12, S_F13, S_F14, S_F15, S_F16, S_DONE
    } t_state;

    t_state            r_state, n_state;
    btffa_pkg::t_off   r_p, n_p, r_pre, n_pre, r_nx, n_nx;
    btffa_pkg::t_word  r_h, n_h, r_a, n_a, r_v, n_v, r_need, n_need;
    logic [BW-1:0]     r_brk, n_brk;
    logic [1:0]        r_status, n_status, r_ostatus;
    logic [13:0]       r_addr, n_addr, r_oaddr;
    logic              r_ovalid;

    // memory port controls
    logic              c_we, c_re;
    btffa_pkg::t_off   c_waddr, c_raddr;
    btffa_pkg::t_word  c_wdata;

    btffa_pkg::t_word  mem [HEAP_WORDS];
    btffa_pkg::t_word  r_q;
    logic              r_oob;
    btffa_pkg::t_word  w_rd;
    btffa_pkg::t_off   w_brk;
    btffa_pkg::t_word  w_sum;
    logic              w_pnz;

    function automatic logic in_range(input btffa_pkg::t_off off);
        in_range = off[31:2] < 30'(HEAP_WORDS);
    endfunction

    // word memory, out-of-range writes dropped and reads flagged
    always_ff @(posedge i_clk) begin
        if (c_we && in_range(c_waddr)) begin
            mem[c_waddr[AW+1:2]] <= c_wdata;
        end
        if (c_re) begin
            r_q   <= mem[c_raddr[AW+1:2]];
            r_oob <= !in_range(c_raddr);
        end
    end

    assign w_rd  = r_oob ? btffa_pkg::END_MARK : r_q;
    assign w_brk = btffa_pkg::t_off'(r_brk);
    assign w_sum = r_a + w_rd;
    assign w_pnz = (r_p != '0);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_ostatus;
    assign m_axis_tdata  = {2'b00, r_oaddr};

    // sequencer next state and memory access
    always_comb begin
        n_state  = r_state;
        n_p      = r_p;
        n_pre    = r_pre;
        n_nx     = r_nx;
        n_h      = r_h;
        n_a      = r_a;
        n_v      = r_v;
        n_need   = r_need;
        n_brk    = r_brk;
        n_status = r_status;
        n_addr   = r_addr;
        c_we     = 1'b0;
        c_re     = 1'b0;
        c_waddr  = r_p;
        c_raddr  = r_p;
        c_wdata  = r_need;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_status = btffa_pkg::ST_OK;
                    n_addr   = '0;
                    if (s_axis_tuser[0] == btffa_pkg::FN_ALLOC) begin
                        n_need  = (16'({2'b00, s_axis_tdata[13:0]}) + 16'd23) & 16'hFFF0;
                        n_p     = '0;
                        n_state = S_A_CHK;
                    end else if (s_axis_tdata[27:14] == '0) begin
                        n_status = btffa_pkg::ST_NULL;
                        n_state  = S_DONE;
                    end else begin
                        n_p     = btffa_pkg::t_off'(s_axis_tdata[27:14])
                                  - btffa_pkg::HDR_BYTES;
                        n_state = S_F0;
                    end
                end
            end
            // first fit walk over block headers
            S_A_CHK: begin
                if (r_p < w_brk) begin
                    c_re    = 1'b1;
                    n_state = S_A_WALK;
                end else begin
                    n_state = S_G0;
                end
            end
            S_A_WALK: begin
                n_h = w_rd;
                if (!w_rd[0] && (w_rd & btffa_pkg::SIZE_MASK) >= r_need) begin
                    n_state = (w_rd != r_need) ? S_SP1 : S_MU0;
                end else if ((w_rd & btffa_pkg::SIZE_MASK) == '0) begin
                    n_state = S_G0;
                end else begin
                    n_p     = r_p + btffa_pkg::t_off'(w_rd & btffa_pkg::SIZE_MASK);
                    n_state = S_A_CHK;
                end
            end
            // grow at the break
            S_G0: begin
                n_p = w_brk;
                if (w_brk + btffa_pkg::t_off'(r_need) > CAP_OFF) begin
                    n_status = btffa_pkg::ST_OOM;
                    n_state  = S_DONE;
                end else begin
                    c_we    = 1'b1;
                    c_waddr = w_brk;
                    n_state = S_G1;
                end
            end
            S_G1: begin
                c_we    = 1'b1;
                c_waddr = r_p + btffa_pkg::t_off'(r_need) - btffa_pkg::HDR_BYTES;
                n_state = S_G2;
            end
            S_G2: begin
                c_we    = 1'b1;
                c_waddr = r_p + btffa_pkg::t_off'(r_need);
                c_wdata = btffa_pkg::END_MARK;
                n_brk   = BW'(r_p + btffa_pkg::t_off'(r_need));
                n_state = S_MU0;
            end
            // split a larger free block
            S_SP1: begin
                c_we    = 1'b1;
                n_state = S_SP2;
            end
            S_SP2: begin
                c_we    = 1'b1;
                c_waddr = r_p + btffa_pkg::t_off'(r_need) - btffa_pkg::HDR_BYTES;
                n_state = S_SP3;
            end
            S_SP3: begin
                c_we    = 1'b1;
                c_waddr = r_p + btffa_pkg::t_off'(r_need);
                c_wdata = r_h - r_need;
                n_state = S_SP4;
            end
            S_SP4: begin
                c_we    = 1'b1;
                c_waddr = r_p + btffa_pkg::t_off'(r_h) - btffa_pkg::HDR_BYTES;
                c_wdata = r_h - r_need;
                n_state = S_MU0;
            end
            // set the allocated flag in header and footer
            S_MU0: begin
                c_re    = 1'b1;
                n_state = S_MU1;
            end
            S_MU1: begin
                n_h     = w_rd;
                c_re    = 1'b1;
                c_raddr = r_p + btffa_pkg::t_off'(w_rd) - btffa_pkg::HDR_BYTES;
                n_state = S_MU2;
            end
            S_MU2: begin
                c_we    = 1'b1;
                c_waddr = r_p + btffa_pkg::t_off'(r_h) - btffa_pkg::HDR_BYTES;
                c_wdata = w_rd | 16'd1;
                n_state = S_MU3;
            end
            S_MU3: begin
                c_we    = 1'b1;
                c_wdata = r_h | 16'd1;
                n_addr  = 14'(r_p + btffa_pkg::HDR_BYTES);
                n_state = S_DONE;
            end
            // free: clear flags
            S_F0: begin
                c_re    = 1'b1;
                n_state = S_F1;
            end
            S_F1: begin
                n_h     = w_rd & btffa_pkg::SIZE_MASK;
                c_we    = 1'b1;
                c_wdata = w_rd & btffa_pkg::SIZE_MASK;
                n_state = S_F2;
            end
            S_F2: begin
                c_re    = 1'b1;
                c_raddr = r_p + btffa_pkg::t_off'(r_h) - btffa_pkg::HDR_BYTES;
                n_nx    = r_p + btffa_pkg::t_off'(r_h);
                n_state = S_F3;
            end
            S_F3: begin
                c_we    = 1'b1;
                c_waddr = r_p + btffa_pkg::t_off'(r_h) - btffa_pkg::HDR_BYTES;
                c_wdata = w_rd & btffa_pkg::SIZE_MASK;
                n_state = S_F4;
            end
            S_F4: begin
                c_re    = 1'b1;
                c_raddr = r_p - btffa_pkg::HDR_BYTES;
                n_state = S_F5;
            end
            // merge with the next block
            S_F5: begin
                n_pre   = r_p - btffa_pkg::t_off'(w_rd & btffa_pkg::SIZE_MASK);
                c_re    = 1'b1;
                c_raddr = r_nx;
                n_state = S_F6;
            end
            S_F6: begin
                if (!w_rd[0]) begin
                    n_a     = w_rd;
                    c_re    = 1'b1;
                    n_state = S_F7;
                end else begin
                    n_state = S_F9;
                end
            end
            S_F7: begin
                n_v     = w_sum;
                c_we    = 1'b1;
                c_wdata = w_sum;
                n_state = S_F8;
            end
            S_F8: begin
                c_we    = 1'b1;
                c_waddr = r_p + btffa_pkg::t_off'(r_v) - btffa_pkg::HDR_BYTES;
                c_wdata = r_v;
                n_state = S_F9;
            end
            // merge with the previous block
            S_F9: begin
                if (w_pnz) begin
                    c_re    = 1'b1;
                    c_raddr = r_pre;
                    n_state = S_F10;
                end else begin
                    n_state = S_F13;
                end
            end
            S_F10: begin
                if (!w_rd[0]) begin
                    n_a     = w_rd;
                    c_re    = 1'b1;
                    n_state = S_F11;
                end else begin
                    n_state = S_F13;
                end
            end
            S_F11: begin
                n_v     = w_sum;
                c_we    = 1'b1;
                c_waddr = r_pre;
                c_wdata = w_sum;
                n_state = S_F12;
            end
            S_F12: begin
                c_we    = 1'b1;
                c_waddr = r_pre + btffa_pkg::t_off'(r_v) - btffa_pkg::HDR_BYTES;
                c_wdata = r_v;
                n_state = S_F13;
            end
            // lower the break when the freed block is last
            S_F13: begin
                c_re    = 1'b1;
                c_raddr = r_nx;
                n_state = S_F14;
            end
            S_F14: begin
                if (w_rd == btffa_pkg::END_MARK) begin
                    c_re = 1'b1;
                    if (w_pnz) begin
                        c_raddr = r_pre;
                        n_state = S_F15;
                    end else begin
                        n_state = S_F16;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_F15: begin
                if (!w_rd[0]) begin
                    n_brk   = (btffa_pkg::t_off'(w_rd) > w_brk) ? '0
                              : BW'(w_brk - btffa_pkg::t_off'(w_rd));
                    c_we    = 1'b1;
                    c_waddr = r_pre;
                    c_wdata = btffa_pkg::END_MARK;
                    n_state = S_DONE;
                end else begin
                    c_re    = 1'b1;
                    n_state = S_F16;
                end
            end
            S_F16: begin
                n_brk   = (btffa_pkg::t_off'(w_rd) > w_brk) ? '0
                          : BW'(w_brk - btffa_pkg::t_off'(w_rd));
                c_we    = w_pnz;
                c_wdata = btffa_pkg::END_MARK;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state, working registers and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_brk    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_brk   <= n_brk;
            if (r_state == S_DONE && (!r_ovalid || m_axis_tready)) begin
                r_ovalid  <= 1'b1;
                r_ostatus <= r_status;
                r_oaddr   <= r_addr;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
        r_p      <= n_p;
        r_pre    <= n_pre;
        r_nx     <= n_nx;
        r_h      <= n_h;
        r_a      <= n_a;
        r_v      <= n_v;
        r_need   <= n_need;
        r_status <= n_status;
        r_addr   <= n_addr;
    end

    `ASSERT_CLK(a_brk_cap, (r_brk <= BW'(CAP)), "break beyond heap capacity")
    `ASSERT_CLK(a_one_access, !(c_we && c_re), "read and write issued together")
    `ASSERT_CLK(a_busy, (s_axis_tvalid && s_axis_tready) |=> (r_state != S_IDLE), "idle")
    `ASSERT_CLK(a_status_code, m_axis_tvalid |-> (m_axis_tuser != 2'd3), "bad status code")

endmodule
